// ===== design/assert_macros.svh =====
// Assertion helpers, included by sqe_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_HOLDS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// cons must hold in the same cycle as ante
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== design/sqe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sqe_pkg;

  localparam int DATA_W = 32;

  // request opcodes
  localparam logic [2:0] MODE_PUSH  = 3'd0;
  localparam logic [2:0] MODE_POP   = 3'd1;
  localparam logic [2:0] MODE_PEEK  = 3'd2;
  localparam logic [2:0] MODE_PRINT = 3'd3;
  localparam logic [2:0] MODE_SWAP  = 3'd4;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_SHORT = 2'd2;
  localparam logic [1:0] ST_FULL  = 2'd3;

  typedef struct packed {
    logic [2:0]               mode;
    logic signed [DATA_W-1:0] push_value;
  } sqe_in_t;

  typedef struct packed {
    logic [1:0]               status;
    logic signed [DATA_W-1:0] read_value;
    logic                     last;
  } sqe_out_t;

endpackage

`default_nettype wire

// ===== design/sqe_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sqe_ram #(
  parameter int DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  wire logic signed [sqe_pkg::DATA_W-1:0] wr_data,
  input  wire logic                              rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]          rd_addr,
  output logic signed [sqe_pkg::DATA_W-1:0]      rd_data
);
  import sqe_pkg::*;

  logic signed [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== design/sqe_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module sqe_ctrl #(
  parameter int DEPTH = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire sqe_pkg::sqe_in_t                  in_data,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output sqe_pkg::sqe_out_t                      out_data,
  output logic                                   mem_wr_en,
  output logic [$clog2(DEPTH)-1:0]               mem_wr_addr,
  output logic signed [sqe_pkg::DATA_W-1:0]      mem_wr_data,
  output logic                                   mem_rd_en,
  output logic [$clog2(DEPTH)-1:0]               mem_rd_addr,
  input  wire logic signed [sqe_pkg::DATA_W-1:0] mem_rd_data
);
  import sqe_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PEEK  = 6'b000010,
    S_PRINT = 6'b000100,
    S_SWAP1 = 6'b001000,
    S_SWAP2 = 6'b010000,
    S_SWAP3 = 6'b100000
  } state_t;

  state_t                   state, state_next;
  logic [IW-1:0]            front, front_next;
  logic [CW-1:0]            count, count_next;
  logic [CW-1:0]            pidx, pidx_next;
  logic [IW-1:0]            rd_slot, rd_slot_next;
  logic [IW-1:0]            swap_b, swap_b_next;
  logic signed [DATA_W-1:0] hold, hold_next;
  logic                     queue_order;
  logic                     out_free;
  logic                     ld;
  sqe_out_t                 ld_item;
  logic [IW-1:0]            front_dec;
  logic [IW-1:0]            slot_inc;
  logic                     print_last;

  // (base + off) mod DEPTH, with off below DEPTH
  function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW + 1)'(base) + (CW + 1)'(off);
    if (s >= (CW + 1)'(DEPTH)) begin
      s = s - (CW + 1)'(DEPTH);
    end
    return s[IW-1:0];
  endfunction

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid || out_ready;
  assign in_ready   = (state == S_IDLE) && out_free;
  assign front_dec  = (front == '0) ? IW'(DEPTH - 1) : front - IW'(1);
  assign slot_inc   = wrap_add(rd_slot, CW'(1));
  assign print_last = (pidx + CW'(1)) == count;

  always_comb begin
    state_next   = state;
    front_next   = front;
    count_next   = count;
    pidx_next    = pidx;
    rd_slot_next = rd_slot;
    swap_b_next  = swap_b;
    hold_next    = hold;
    ld           = 1'b0;
    ld_item      = '0;
    ld_item.last = 1'b1;
    mem_wr_en    = 1'b0;
    mem_wr_addr  = front;
    mem_wr_data  = in_data.push_value;
    mem_rd_en    = 1'b0;
    mem_rd_addr  = front;

    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          unique case (in_data.mode)
            MODE_PUSH: begin
              ld = 1'b1;
              if (count == CW'(DEPTH)) begin
                ld_item.status = ST_FULL;
              end else begin
                mem_wr_en = 1'b1;
                if (queue_order) begin
                  mem_wr_addr = wrap_add(front, count);
                end else begin
                  mem_wr_addr = front_dec;
                  front_next  = front_dec;
                end
                count_next = count + CW'(1);
              end
            end
            MODE_POP: begin
              ld = 1'b1;
              if (count == '0) begin
                ld_item.status = ST_EMPTY;
              end else begin
                front_next = wrap_add(front, CW'(1));
                count_next = count - CW'(1);
              end
            end
            MODE_PEEK: begin
              if (count == '0) begin
                ld             = 1'b1;
                ld_item.status = ST_EMPTY;
              end else begin
                mem_rd_en  = 1'b1;
                state_next = S_PEEK;
              end
            end
            MODE_PRINT: begin
              // empty store: no result at all
              if (count != '0) begin
                mem_rd_en    = 1'b1;
                rd_slot_next = front;
                pidx_next    = '0;
                state_next   = S_PRINT;
              end
            end
            MODE_SWAP: begin
              if (count < CW'(2)) begin
                ld             = 1'b1;
                ld_item.status = ST_SHORT;
              end else begin
                mem_rd_en   = 1'b1;
                swap_b_next = wrap_add(front, CW'(1));
                state_next  = S_SWAP1;
              end
            end
            default: begin
              ld = 1'b1;
            end
          endcase
        end
      end
      S_PEEK: begin
        if (out_free) begin
          ld                 = 1'b1;
          ld_item.read_value = mem_rd_data;
          state_next         = S_IDLE;
        end
      end
      S_PRINT: begin
        if (out_free) begin
          ld                 = 1'b1;
          ld_item.read_value = mem_rd_data;
          ld_item.last       = print_last;
          if (print_last) begin
            state_next = S_IDLE;
          end else begin
            pidx_next    = pidx + CW'(1);
            rd_slot_next = slot_inc;
            mem_rd_en    = 1'b1;
            mem_rd_addr  = slot_inc;
          end
        end
      end
      S_SWAP1: begin
        hold_next   = mem_rd_data;
        mem_rd_en   = 1'b1;
        mem_rd_addr = swap_b;
        state_next  = S_SWAP2;
      end
      S_SWAP2: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = front;
        mem_wr_data = mem_rd_data;
        state_next  = S_SWAP3;
      end
      S_SWAP3: begin
        // rewrite while stalled is harmless
        mem_wr_en   = 1'b1;
        mem_wr_addr = swap_b;
        mem_wr_data = hold;
        if (out_free) begin
          ld         = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front       <= '0;
      count       <= '0;
      pidx        <= '0;
      rd_slot     <= '0;
      queue_order <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state   <= state_next;
      front   <= front_next;
      count   <= count_next;
      pidx    <= pidx_next;
      rd_slot <= rd_slot_next;
      if (cfg_valid && cfg_ready) begin
        queue_order <= cfg_data;
      end
      if (ld) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    swap_b <= swap_b_next;
    hold   <= hold_next;
    if (ld) begin
      out_data <= ld_item;
    end
  end

  `ASSERT_HOLDS(a_count_max, clk, rst, count <= CW'(DEPTH))
  `ASSERT_HOLDS(a_front_range, clk, rst, front < IW'(DEPTH - 1) || front == IW'(DEPTH - 1))
  `ASSERT_IMPL(a_print_idx, clk, rst, state == S_PRINT, pidx < count)
  `ASSERT_IMPL(a_swap_count, clk, rst, state == S_SWAP1 || state == S_SWAP2 || state == S_SWAP3, count >= CW'(2))
  `ASSERT_NEXT(a_peek_go, clk, rst, in_valid && in_ready && in_data.mode == MODE_PEEK && count != '0, state == S_PEEK)

endmodule

`default_nettype wire

// ===== design/stack_queue_engine.sv =====
// Stack / queue engine: a bounded ring store of signed 32-bit values.
// Input channel (in_valid/in_ready/in_data) takes one request: push, pop,
// peek, print-all or swap-top-two. Output channel (out_valid/out_ready/
// out_data) returns results with status, read value and a last marker.
// Config channel (cfg_valid/cfg_ready/cfg_data) sets queue_order:
// 0 pushes at the front (stack), 1 at the back (queue). Write it while idle.
// Push, pop and unused codes load a result with no memory read; peek and
// print-all first read the entry memory; swap steps through S_SWAP1 to
// S_SWAP3. Print-all then streams one element per cycle while out_ready
// allows; print-all on an empty store gives nothing. Requests are taken
// one at a time, set by the read/modify/write sequence on the entry memory
// (one read port, one write port, registered read): push/pop every cycle.
// Results sit in an output register; a stalled receiver holds it and the
// engine waits, with no result lost. A new request is taken while the last
// result still waits only if out_ready is high in that cycle.
// Reset (rst, synchronous) empties the store and sets stack order; the entry
// memory is not cleared, only written slots are ever read.
`timescale 1ns / 1ps
`default_nettype none

module stack_queue_engine #(
  parameter int DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic              cfg_data,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sqe_pkg::sqe_in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output sqe_pkg::sqe_out_t      out_data
);
  import sqe_pkg::*;

  localparam int IW = $clog2(DEPTH);

  // entry memory port
  logic                     mem_wr_en;
  logic [IW-1:0]            mem_wr_addr;
  logic signed [DATA_W-1:0] mem_wr_data;
  logic                     mem_rd_en;
  logic [IW-1:0]            mem_rd_addr;
  logic signed [DATA_W-1:0] mem_rd_data;

  // sequencer: front pointer, fill count, op decode, output register
  sqe_ctrl #(
    .DEPTH(DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .mem_wr_en  (mem_wr_en),
    .mem_wr_addr(mem_wr_addr),
    .mem_wr_data(mem_wr_data),
    .mem_rd_en  (mem_rd_en),
    .mem_rd_addr(mem_rd_addr),
    .mem_rd_data(mem_rd_data)
  );

  // entry store, registered read
  sqe_ram #(
    .DEPTH(DEPTH)
  ) u_ram (
    .clk    (clk),
    .wr_en  (mem_wr_en),
    .wr_addr(mem_wr_addr),
    .wr_data(mem_wr_data),
    .rd_en  (mem_rd_en),
    .rd_addr(mem_rd_addr),
    .rd_data(mem_rd_data)
  );

endmodule

`default_nettype wire
